>>> hdl/cmf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmf_pkg
// Shared constants, codes and types of the plus-shaped median filter.
// ----------------------------------------------------------------------------
package cmf_pkg;

   localparam int MAX_WIDTH     = 1024;
   localparam int PIX_BITS      = 8;
   localparam int COL_BITS      = $clog2(MAX_WIDTH);
   localparam int WID_BITS      = 11;
   localparam int HGT_BITS      = 16;

   localparam int CSR_IDX_BITS  = 1;
   localparam int CSR_DATA_BITS = 16;

   localparam logic [CSR_IDX_BITS-1:0] CSR_FRAME_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FRAME_HEIGHT = 1'd1;

   localparam logic [WID_BITS-1:0] WIDTH_RESET  = 11'd640;
   localparam logic [HGT_BITS-1:0] HEIGHT_RESET = 16'd480;
   localparam logic [WID_BITS-1:0] WIDTH_LIMIT  = WID_BITS'(MAX_WIDTH);

   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_DRAIN = 1'b1;

   // operation codes carried from front to back
   localparam logic OP_STORE = 1'b0;
   localparam logic OP_EMIT  = 1'b1;

   localparam int Q_DEPTH      = 4;
   localparam int Q_PTR_BITS   = $clog2(Q_DEPTH);
   localparam int Q_CNT_BITS   = $clog2(Q_DEPTH + 1);

   localparam int OUT_DEPTH    = 3;
   localparam int OUT_PTR_BITS = $clog2(OUT_DEPTH);
   localparam int OUT_CNT_BITS = $clog2(OUT_DEPTH + 1);

   typedef struct packed {
      logic                op;
      logic [COL_BITS-1:0] col;
      logic [PIX_BITS-1:0] pixel;
      logic                up_zero;
      logic                left_zero;
      logic                right_zero;
      logic                last;
   } cmf_op_type;

   typedef struct packed {
      logic full;
      logic head_valid;
   } cmf_q_stat_type;

endpackage

>>> hdl/cmf_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmf_if
// Valid/ready channels of the median filter: pixel requests and results.
// ----------------------------------------------------------------------------
interface cmf_req_if import cmf_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                kind;
   logic [PIX_BITS-1:0] pixel_value;

   modport source (output valid, kind, pixel_value, input ready);
   modport sink   (input valid, kind, pixel_value, output ready);
endinterface

interface cmf_rsp_if import cmf_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [PIX_BITS-1:0] median_value;
   logic                last_of_frame;

   modport source (output valid, median_value, last_of_frame, input ready);
   modport sink   (input valid, median_value, last_of_frame, output ready);
endinterface

>>> hdl/cmf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmf_front
// Raster position tracking: classifies each transaction as store, emit or
// ignored and pushes line-store operations into the queue.
// ----------------------------------------------------------------------------
module cmf_front import cmf_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   cmf_req_if.sink             req_chan,
   input  logic [WID_BITS-1:0] frame_width,
   input  logic [HGT_BITS-1:0] frame_height,
   input  cmf_q_stat_type      q_stat,
   output logic                push,
   output cmf_op_type          push_op
);

   logic [COL_BITS-1:0] col_ff, col_in;
   logic [HGT_BITS-1:0] row_ff, row_in;
   logic [COL_BITS-1:0] drain_ff, drain_in;

   logic [WID_BITS-1:0] w_eff, w_max_col;
   logic [HGT_BITS-1:0] h_eff;
   logic                accept, complete, skip, wrap, last;
   logic [COL_BITS-1:0] col0, d;
   logic [HGT_BITS-1:0] row0;
   logic [WID_BITS-1:0] nc, dn;

   assign req_chan.ready = !q_stat.full;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      if (frame_width == '0) begin
         w_eff = WID_BITS'(1);
      end else if (frame_width > WIDTH_LIMIT) begin
         w_eff = WIDTH_LIMIT;
      end else begin
         w_eff = frame_width;
      end
      h_eff     = (frame_height == '0) ? HGT_BITS'(1) : frame_height;
      w_max_col = w_eff - WID_BITS'(1);
      complete  = row_ff >= h_eff;

      // pixel path: a row shortened mid-frame closes before this pixel
      col0 = col_ff;
      row0 = row_ff;
      skip = 1'b0;
      if ({1'b0, col_ff} >= w_eff) begin
         col0 = '0;
         row0 = row_ff + HGT_BITS'(1);
         skip = row0 >= h_eff;
      end
      nc   = {1'b0, col0} + WID_BITS'(1);
      wrap = nc >= w_eff;

      // drain path
      d    = ({1'b0, drain_ff} >= w_eff) ? w_max_col[COL_BITS-1:0] : drain_ff;
      dn   = {1'b0, d} + WID_BITS'(1);
      last = dn >= w_eff;

      col_in   = col_ff;
      row_in   = row_ff;
      drain_in = drain_ff;
      push     = 1'b0;
      push_op  = '0;

      if (accept) begin
         if (req_chan.kind == KIND_PIXEL) begin
            if (!complete) begin
               if (skip) begin
                  col_in = '0;
                  row_in = row0;
               end else begin
                  col_in             = wrap ? '0 : nc[COL_BITS-1:0];
                  row_in             = wrap ? row0 + HGT_BITS'(1) : row0;
                  push               = 1'b1;
                  // first row only fills the line store
                  push_op.op         = (row0 == '0) ? OP_STORE : OP_EMIT;
                  push_op.col        = col0;
                  push_op.pixel      = req_chan.pixel_value;
                  push_op.up_zero    = row0 <= HGT_BITS'(1);
                  push_op.left_zero  = col0 == '0;
                  push_op.right_zero = wrap;
                  push_op.last       = 1'b0;
               end
            end
         end else if (complete) begin
            push               = 1'b1;
            push_op.op         = OP_EMIT;
            push_op.col        = d;
            push_op.pixel      = '0;
            push_op.up_zero    = row_ff <= HGT_BITS'(1);
            push_op.left_zero  = d == '0;
            push_op.right_zero = last;
            push_op.last       = last;
            if (last) begin
               drain_in = '0;
               row_in   = '0;
               col_in   = '0;
            end else begin
               drain_in = dn[COL_BITS-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         row_ff   <= '0;
         drain_ff <= '0;
      end else begin
         col_ff   <= col_in;
         row_ff   <= row_in;
         drain_ff <= drain_in;
      end
   end

endmodule

>>> hdl/cmf_op_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmf_op_queue
// Short first-in first-out queue of line-store operations between the
// front and the back.
// ----------------------------------------------------------------------------
module cmf_op_queue import cmf_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  cmf_op_type     push_op,
   input  logic           pop,
   output cmf_q_stat_type q_stat,
   output cmf_op_type     head_op
);

   cmf_op_type              entries_ff [Q_DEPTH];
   logic [Q_PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_BITS-1:0]   count_ff, count_in;

   assign q_stat.full       = count_ff == Q_CNT_BITS'(Q_DEPTH);
   assign q_stat.head_valid = count_ff != '0;
   assign head_op           = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + Q_PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + Q_PTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + Q_CNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - Q_CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

>>> hdl/cmf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmf_back
// Line stores, window gather with write bypass, five-point median and the
// result buffer.
// ----------------------------------------------------------------------------
module cmf_back import cmf_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  cmf_q_stat_type q_stat,
   input  cmf_op_type     head_op,
   output logic           pop,
   cmf_rsp_if.source      rsp_chan
);

   // line stores: newest complete row and the one before it
   logic [PIX_BITS-1:0] above_row_ff [MAX_WIDTH];
   logic [PIX_BITS-1:0] upper_row_ff [MAX_WIDTH];

   logic [PIX_BITS-1:0] up_rd_ff, left_rd_ff, ctr_rd_ff, right_rd_ff;
   logic                s1_valid_ff, s1_valid_in;
   cmf_op_type          s1_op_ff;

   // write to the upper row committed at the last edge
   logic                byp_valid_ff;
   logic [COL_BITS-1:0] byp_col_ff;
   logic [PIX_BITS-1:0] byp_data_ff;

   logic [PIX_BITS-1:0] med_buf_ff [OUT_DEPTH];
   logic                last_buf_ff [OUT_DEPTH];
   logic [OUT_PTR_BITS-1:0] out_wr_ff, out_wr_in, out_rd_ff, out_rd_in;
   logic [OUT_CNT_BITS-1:0] out_cnt_ff, out_cnt_in;
   logic [OUT_CNT_BITS:0]   occupancy;
   logic                    out_pop;

   logic [COL_BITS-1:0] left_col, right_col;
   logic [PIX_BITS-1:0] win [5];
   logic [2:0]          rank [5];
   logic [PIX_BITS-1:0] median;

   assign left_col  = head_op.col - COL_BITS'(1);
   assign right_col = head_op.col + COL_BITS'(1);

   // results in flight never exceed the buffer depth
   assign occupancy = {1'b0, out_cnt_ff} + (OUT_CNT_BITS+1)'(s1_valid_ff);
   assign pop       = q_stat.head_valid && (occupancy < (OUT_CNT_BITS+1)'(OUT_DEPTH));
   assign s1_valid_in = pop && (head_op.op == OP_EMIT);

   always_ff @(posedge clock) begin
      if (pop) begin
         up_rd_ff    <= upper_row_ff[head_op.col];
         left_rd_ff  <= upper_row_ff[left_col];
         ctr_rd_ff   <= above_row_ff[head_op.col];
         right_rd_ff <= above_row_ff[right_col];
         above_row_ff[head_op.col] <= head_op.pixel;
         s1_op_ff    <= head_op;
      end
      if (s1_valid_ff) begin
         upper_row_ff[s1_op_ff.col] <= ctr_rd_ff;
      end
      byp_col_ff  <= s1_op_ff.col;
      byp_data_ff <= ctr_rd_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         byp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         byp_valid_ff <= s1_valid_ff;
      end
   end

   always_comb begin
      if (s1_op_ff.up_zero) begin
         win[0] = '0;
      end else if (byp_valid_ff && byp_col_ff == s1_op_ff.col) begin
         win[0] = byp_data_ff;
      end else begin
         win[0] = up_rd_ff;
      end
      if (s1_op_ff.left_zero) begin
         win[1] = '0;
      end else if (byp_valid_ff && byp_col_ff == s1_op_ff.col - COL_BITS'(1)) begin
         win[1] = byp_data_ff;
      end else begin
         win[1] = left_rd_ff;
      end
      win[2] = ctr_rd_ff;
      win[3] = s1_op_ff.right_zero ? '0 : right_rd_ff;
      win[4] = s1_op_ff.pixel;
   end

   // rank each value with ties broken by position; rank two is the median
   always_comb begin
      median = '0;
      for (int i = 0; i < 5; i++) begin
         rank[i] = '0;
         for (int j = 0; j < 5; j++) begin
            if (j != i && (win[j] < win[i] || (win[j] == win[i] && j < i))) begin
               rank[i] = rank[i] + 3'd1;
            end
         end
      end
      for (int i = 0; i < 5; i++) begin
         if (rank[i] == 3'd2) begin
            median = win[i];
         end
      end
   end

   // result buffer
   assign rsp_chan.valid         = out_cnt_ff != '0;
   assign rsp_chan.median_value  = med_buf_ff[out_rd_ff];
   assign rsp_chan.last_of_frame = last_buf_ff[out_rd_ff];
   assign out_pop                = rsp_chan.valid && rsp_chan.ready;

   always_comb begin
      out_wr_in = out_wr_ff;
      out_rd_in = out_rd_ff;
      if (s1_valid_ff) begin
         out_wr_in = (out_wr_ff == OUT_PTR_BITS'(OUT_DEPTH - 1)) ? '0
                   : out_wr_ff + OUT_PTR_BITS'(1);
      end
      if (out_pop) begin
         out_rd_in = (out_rd_ff == OUT_PTR_BITS'(OUT_DEPTH - 1)) ? '0
                   : out_rd_ff + OUT_PTR_BITS'(1);
      end
      out_cnt_in = out_cnt_ff;
      if (s1_valid_ff && !out_pop) begin
         out_cnt_in = out_cnt_ff + OUT_CNT_BITS'(1);
      end else if (out_pop && !s1_valid_ff) begin
         out_cnt_in = out_cnt_ff - OUT_CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_wr_ff  <= '0;
         out_rd_ff  <= '0;
         out_cnt_ff <= '0;
      end else begin
         out_wr_ff  <= out_wr_in;
         out_rd_ff  <= out_rd_in;
         out_cnt_ff <= out_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         med_buf_ff[out_wr_ff]  <= median;
         last_buf_ff[out_wr_ff] <= s1_op_ff.last;
      end
   end

endmodule

>>> hdl/cross_median_filter_unit.sv
`timescale 1ns / 1ps
// order: a result passes through the queue, the line store read, the median and
//   the result buffer, in that order, before it can be taken
// throughput: one transaction per cycle, set by one pass through the line
//   stores per transaction; a full result buffer holds the front back through the queue
// reset: synchronous, active high; clears counters, queues and registers to
//   width 640 and height 480; line stores are not cleared
// ----------------------------------------------------------------------------
// cross_median_filter_unit
// Plus-shaped five-point median filter over a raster pixel stream with
// zero border, two line stores and drain transactions after the frame.
// ----------------------------------------------------------------------------
module cross_median_filter_unit import cmf_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   cmf_req_if.sink                  req_chan,
   cmf_rsp_if.source                rsp_chan,
   input  logic                     csr_wr_en,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wr_data
);

   logic [WID_BITS-1:0] frame_width_ff;
   logic [HGT_BITS-1:0] frame_height_ff;

   logic           push, pop;
   cmf_op_type     push_op, head_op;
   cmf_q_stat_type q_stat;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= WIDTH_RESET;
         frame_height_ff <= HEIGHT_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_wr_data[WID_BITS-1:0];
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_wr_data[HGT_BITS-1:0];
            default: ;
         endcase
      end
   end

   cmf_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_chan),
      .frame_width  (frame_width_ff),
      .frame_height (frame_height_ff),
      .q_stat       (q_stat),
      .push         (push),
      .push_op      (push_op)
   );

   cmf_op_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_op (push_op),
      .pop     (pop),
      .q_stat  (q_stat),
      .head_op (head_op)
   );

   cmf_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_stat   (q_stat),
      .head_op  (head_op),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule
